// ----- rtl/rpq_pkg.sv -----
// Shared types and constants of the rotary position qualifier.
`default_nettype none

package rpq_pkg;

  localparam int LINE_W   = 8;
  localparam int TIME_W   = 64;
  localparam int STABLE_W = 20;
  localparam int POS_W    = 3;
  localparam int KIND_W   = 2;
  localparam int CNT_W    = 4;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_STABLE_TIME = 1'b0;
  localparam logic [STABLE_W-1:0]  STABLE_RESET    = 20'd30000;

  typedef enum logic [KIND_W-1:0] {
    KIND_GAP      = 2'd0,
    KIND_UNIQUE   = 2'd1,
    KIND_MULTIPLE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LINE_W-1:0] lines;
    logic [TIME_W-1:0] now;
  } smp_t;

  typedef struct packed {
    logic valid;
    smp_t smp;
  } stg_t;

endpackage

`default_nettype wire

// ----- rtl/rpq_sample_if.sv -----
// Input channel: one switch sample per beat.
`default_nettype none

interface rpq_sample_if;
  logic                          valid;
  logic                          ready;
  logic [rpq_pkg::LINE_W-1:0]    position_lines;
  logic [rpq_pkg::TIME_W-1:0]    now_us;

  modport source (output valid, output position_lines, output now_us, input ready);
  modport sink   (input valid, input position_lines, input now_us, output ready);
endinterface

`default_nettype wire

// ----- rtl/rpq_result_if.sv -----
// Result channel: one classified sample per beat.
`default_nettype none

interface rpq_result_if;
  logic                          valid;
  logic                          ready;
  logic [rpq_pkg::KIND_W-1:0]    reading_kind;
  logic                          position_accepted;
  logic [rpq_pkg::POS_W-1:0]     accepted_position;
  logic                          fault_warning;

  modport source (output valid, output reading_kind, output position_accepted,
                  output accepted_position, output fault_warning, input ready);
  modport sink   (input valid, input reading_kind, input position_accepted,
                  input accepted_position, input fault_warning, output ready);
endinterface

`default_nettype wire

// ----- rtl/rpq_apb_regs.sv -----
// APB register file holding the stable time.
`default_nettype none

module rpq_apb_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rpq_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [rpq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [rpq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [rpq_pkg::STABLE_W-1:0]      stable_time
);
  import rpq_pkg::*;

  logic [STABLE_W-1:0]  stable_r;
  logic [STABLE_W-1:0]  stable_nxt;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    stable_nxt = stable_r;
    if (psel && penable && pwrite && reg_idx == REG_STABLE_TIME) begin
      stable_nxt = pwdata[STABLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= STABLE_RESET;
    end else begin
      stable_r <= stable_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_STABLE_TIME) begin
      prdata = {{(APB_DATA_W-STABLE_W){1'b0}}, stable_r};
    end
  end

  assign stable_time = stable_r;

endmodule

`default_nettype wire

// ----- rtl/rpq_in_stage.sv -----
// Input register stage that captures one sample beat.
`default_nettype none

module rpq_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  rpq_sample_if.sink           in_ch,
  output rpq_pkg::stg_t        stg,
  input  wire logic            stg_ready
);
  import rpq_pkg::*;

  logic valid_r;
  logic valid_nxt;
  smp_t smp_r;
  smp_t smp_nxt;
  logic take;

  assign in_ch.ready = !valid_r || stg_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    smp_nxt   = smp_r;
    if (take) begin
      valid_nxt     = 1'b1;
      smp_nxt.lines = in_ch.position_lines;
      smp_nxt.now   = in_ch.now_us;
    end else if (stg_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
  end

  assign stg.valid = valid_r;
  assign stg.smp   = smp_r;

endmodule

`default_nettype wire

// ----- rtl/rpq_qualify.sv -----
// Sample classification, candidate and fault tracking, and result register.
`default_nettype none

module rpq_qualify #(
  parameter int SAMPLED = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rpq_pkg::stg_t                  stg,
  output logic                                stg_ready,
  input  wire logic [rpq_pkg::STABLE_W-1:0]   stable_time,
  rpq_result_if.source                        out_ch
);
  import rpq_pkg::*;

  // Switch state.
  logic              cand_valid_r, cand_valid_nxt;
  logic [POS_W-1:0]  cand_pos_r, cand_pos_nxt;
  logic [TIME_W-1:0] cand_start_r, cand_start_nxt;
  logic              acc_valid_r, acc_valid_nxt;
  logic [POS_W-1:0]  acc_idx_r, acc_idx_nxt;
  logic              fault_ep_r, fault_ep_nxt;
  logic              fault_warned_r, fault_warned_nxt;
  logic [TIME_W-1:0] fault_start_r, fault_start_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic              accepted_r, accepted_nxt;
  logic [POS_W-1:0]  acc_pos_r, acc_pos_nxt;
  logic              warn_r, warn_nxt;

  logic [LINE_W-1:0] low;
  logic [CNT_W-1:0]  cnt;
  logic [POS_W-1:0]  pos;
  kind_t             kind;
  logic [TIME_W-1:0] cand_age;
  logic [TIME_W-1:0] fault_age;
  logic              cand_due;
  logic              fault_due;
  logic              fire;

  assign stg_ready = !out_valid_r || out_ch.ready;
  assign fire      = stg.valid && stg_ready;

  always_comb begin
    low = ~stg.smp.lines;
    cnt = '0;
    pos = '0;
    for (int i = 0; i < SAMPLED; i++) begin
      if (low[i]) begin
        cnt = cnt + CNT_W'(1);
        pos = POS_W'(i);
      end
    end
    if (cnt == '0) begin
      kind = KIND_GAP;
    end else if (cnt == CNT_W'(1)) begin
      kind = KIND_UNIQUE;
    end else begin
      kind = KIND_MULTIPLE;
    end
  end

  // Ages wrap modulo 2^64, so a plain subtraction is enough.
  assign cand_age  = stg.smp.now - cand_start_r;
  assign fault_age = stg.smp.now - fault_start_r;
  assign cand_due  = cand_age >= {{(TIME_W-STABLE_W){1'b0}}, stable_time};
  assign fault_due = fault_age >= {{(TIME_W-STABLE_W){1'b0}}, stable_time};

  always_comb begin
    cand_valid_nxt   = cand_valid_r;
    cand_pos_nxt     = cand_pos_r;
    cand_start_nxt   = cand_start_r;
    acc_valid_nxt    = acc_valid_r;
    acc_idx_nxt      = acc_idx_r;
    fault_ep_nxt     = fault_ep_r;
    fault_warned_nxt = fault_warned_r;
    fault_start_nxt  = fault_start_r;
    out_valid_nxt    = out_valid_r;
    kind_nxt         = kind_r;
    accepted_nxt     = accepted_r;
    acc_pos_nxt      = acc_pos_r;
    warn_nxt         = warn_r;

    if (fire) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = kind;
      accepted_nxt  = 1'b0;
      acc_pos_nxt   = '0;
      warn_nxt      = 1'b0;
      unique case (kind)
        KIND_GAP: begin
          cand_valid_nxt   = 1'b0;
          fault_ep_nxt     = 1'b0;
          fault_warned_nxt = 1'b0;
        end
        KIND_MULTIPLE: begin
          cand_valid_nxt = 1'b0;
          if (!fault_ep_r) begin
            fault_ep_nxt     = 1'b1;
            fault_warned_nxt = 1'b0;
            fault_start_nxt  = stg.smp.now;
          end else if (!fault_warned_r && fault_due) begin
            fault_warned_nxt = 1'b1;
            warn_nxt         = 1'b1;
          end
        end
        KIND_UNIQUE: begin
          fault_ep_nxt     = 1'b0;
          fault_warned_nxt = 1'b0;
          if (!cand_valid_r || cand_pos_r != pos) begin
            cand_valid_nxt = 1'b1;
            cand_pos_nxt   = pos;
            cand_start_nxt = stg.smp.now;
          end else if (cand_due && !(acc_valid_r && acc_idx_r == cand_pos_r)) begin
            acc_valid_nxt = 1'b1;
            acc_idx_nxt   = cand_pos_r;
            accepted_nxt  = 1'b1;
            acc_pos_nxt   = cand_pos_r;
          end
        end
        default: begin
        end
      endcase
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_valid_r   <= 1'b0;
      cand_pos_r     <= '0;
      acc_valid_r    <= 1'b0;
      acc_idx_r      <= '0;
      fault_ep_r     <= 1'b0;
      fault_warned_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      cand_valid_r   <= cand_valid_nxt;
      cand_pos_r     <= cand_pos_nxt;
      acc_valid_r    <= acc_valid_nxt;
      acc_idx_r      <= acc_idx_nxt;
      fault_ep_r     <= fault_ep_nxt;
      fault_warned_r <= fault_warned_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_start_r  <= cand_start_nxt;
    fault_start_r <= fault_start_nxt;
    kind_r        <= kind_nxt;
    accepted_r    <= accepted_nxt;
    acc_pos_r     <= acc_pos_nxt;
    warn_r        <= warn_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.reading_kind      = kind_r;
  assign out_ch.position_accepted = accepted_r;
  assign out_ch.accepted_position = acc_pos_r;
  assign out_ch.fault_warning     = warn_r;

endmodule

`default_nettype wire

// ----- rtl/rotary_position_qualifier.sv -----
// Top level of the rotary position qualifier.
//
//   port group  dir   carries
//   in_ch       in    position_lines, now_us (valid/ready)
//   out_ch      out   reading_kind, position_accepted, accepted_position,
//                     fault_warning (valid/ready)
//   psel..      in    APB write/read of stable_time_us at address 0
//
// One sample per clock is taken while out_ch is not stalled. An accepted beat
// lands in the input register, and its result is then registered onto out_ch.
// The 64-bit age subtract and compare between the two registers set the clock
// period; throughput stays one sample per cycle unless out_ch stalls.
// Synchronous active-low reset clears the switch-state flags and positions and
// the valid bits of both stages, and loads stable_time_us with 30000.
// A stalled result holds the input stage, which then stalls the input channel.
`default_nettype none

module rotary_position_qualifier #(
  parameter int POSITIONS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rpq_sample_if.sink                             in_ch,
  rpq_result_if.source                           out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rpq_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [rpq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [rpq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);
  import rpq_pkg::*;

  // Lines above the sampled width cannot be selected.
  localparam int SAMPLED = (POSITIONS < LINE_W) ? POSITIONS : LINE_W;

  stg_t                stg;
  logic                stg_ready;
  logic [STABLE_W-1:0] stable_time;

  rpq_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .stable_time (stable_time)
  );

  rpq_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .stg       (stg),
    .stg_ready (stg_ready)
  );

  rpq_qualify #(
    .SAMPLED (SAMPLED)
  ) u_qual (
    .clk         (clk),
    .rst_n       (rst_n),
    .stg         (stg),
    .stg_ready   (stg_ready),
    .stable_time (stable_time),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/rpq_checker.sv -----
// Port-level checks of the rotary position qualifier and their bind.
`default_nettype none

module rpq_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [rpq_pkg::KIND_W-1:0]     reading_kind,
  input wire logic                           position_accepted,
  input wire logic [rpq_pkg::POS_W-1:0]      accepted_position,
  input wire logic                           fault_warning
);
  import rpq_pkg::*;

  // An acceptance only comes from a sample with exactly one line low.
  a_accept_unique: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && position_accepted |-> reading_kind == KIND_UNIQUE)
    else $error("position accepted on a sample that is not unique");

  // A warning only comes from a sample with several lines low.
  a_warn_multiple: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fault_warning |-> reading_kind == KIND_MULTIPLE)
    else $error("fault warning on a sample that is not multiple");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !position_accepted |-> accepted_position == '0)
    else $error("accepted_position nonzero without an acceptance");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reading_kind) &&
      $stable(position_accepted) && $stable(accepted_position) && $stable(fault_warning))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rotary_position_qualifier rpq_checker u_rpq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .reading_kind      (out_ch.reading_kind),
  .position_accepted (out_ch.position_accepted),
  .accepted_position (out_ch.accepted_position),
  .fault_warning     (out_ch.fault_warning)
);

`default_nettype wire
